### rtl/flsw_pkg.sv
// Shared types and constants of the framed link stop-and-wait engine.
// Used by the parser, the top level, the checker and the testbench.
// Has no dependencies of its own.
package flsw_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_RX_BYTE = 2'd1;
	localparam logic [1:0] OP_KEY     = 2'd2;
	localparam logic [1:0] OP_TX_DONE = 2'd3;

	// Configuration register indexes (byte address 4*index).
	localparam int unsigned PADDR_W = 4;
	localparam logic [1:0] REG_RETRY_INTERVAL = 2'd0;
	localparam logic [1:0] REG_RETRY_LIMIT    = 2'd1;
	localparam logic [1:0] REG_MAX_DATA_LEN   = 2'd2;

	localparam logic [5:0] RETRY_INTERVAL_RST = 6'd10;
	localparam logic [2:0] RETRY_LIMIT_RST    = 3'd3;
	localparam logic [4:0] MAX_DATA_LEN_RST   = 5'd20;

	// Frame bytes.
	localparam logic [7:0] FRAME_SOF     = 8'hAA;
	localparam logic [7:0] FRAME_EOF     = 8'hBB;
	localparam logic [7:0] CMD_ACK_LIMIT = 8'h80;
	localparam logic [7:0] CMD_KEY_EVENT = 8'h90;
	localparam logic [7:0] KEY_DATA_LEN  = 8'd2;

	// Frame kinds on the transmit side.
	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_FIRST = 2'd1;
	localparam logic [1:0] KIND_RETRY = 2'd2;

	// A complete, checked frame seen by the receive parser.
	typedef struct packed {
		logic       good;
		logic [7:0] command;
	} rx_frame_t;

endpackage

### rtl/flsw_item_if.sv
// Input channel of the framed link engine: one operation per beat.
// Depends on nothing.
interface flsw_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_data;
	logic [7:0] key_code;
	logic [7:0] key_action;

	modport source (output valid, operation, rx_data, key_code, key_action, input ready);
	modport sink (input valid, operation, rx_data, key_code, key_action, output ready);
endinterface

### rtl/flsw_beat_if.sv
// Output channel of the framed link engine: one transmitted frame byte per beat.
// Depends on nothing.
interface flsw_beat_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_data;
	logic       frame_end;
	logic [1:0] frame_kind;
	logic       head_dropped;

	modport source (output valid, tx_data, frame_end, frame_kind, head_dropped, input ready);
	modport sink (input valid, tx_data, frame_end, frame_kind, head_dropped, output ready);
endinterface

### rtl/framed_link_stop_and_wait_engine.sv
// Top level of the framed link stop-and-wait engine.
// Depends on flsw_pkg, flsw_item_if, flsw_beat_if, flsw_ram and flsw_parser.
//
//  channel  | dir | beat contents                                  | accepted when
//  ---------+-----+------------------------------------------------+-----------------------
//  item     | in  | operation, rx_data, key_code, key_action        | item.valid & item.ready
//  beat     | out | tx_data, frame_end, frame_kind, head_dropped    | beat.valid & beat.ready
//  APB      | in  | retry_interval, retry_limit, max_data_len       | psel & penable & pwrite
//
// Items pass an input register and are executed from it, one per clock unless a tick waits there.
// A tick that starts a frame loads the transmit register, which gives 5 beats (reply)
// or 7 beats (key event frame), one per cycle that the sink is ready.
// Any tick waits in the input register while a frame is still being shifted out and
// the link has already been released; other items go on.
// Reset clears all control state; the event queue RAM is not cleared.
module framed_link_stop_and_wait_engine #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	flsw_item_if.sink                     item,
	flsw_beat_if.source                   beat,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	localparam logic [2:0] SLOT_SOF = 3'd0;
	localparam logic [2:0] SLOT_LEN = 3'd1;
	localparam logic [2:0] SLOT_CMD = 3'd2;
	localparam logic [2:0] SLOT_D0  = 3'd3;
	localparam logic [2:0] SLOT_D1  = 3'd4;
	localparam logic [2:0] SLOT_XOR = 3'd5;
	localparam logic [2:0] SLOT_EOF = 3'd6;

	// Configuration.
	logic [5:0] retry_interval_q;
	logic [2:0] retry_limit_q;
	logic [4:0] max_data_len_q;
	logic       cfg_write;

	// Input register.
	logic       valid_s1;
	logic [1:0] operation_s1;
	logic [7:0] rx_data_s1;
	logic [7:0] key_code_s1;
	logic [7:0] key_action_s1;
	logic       s1_go;
	logic       s1_fire;

	// Link state.
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             link_busy_q, link_busy_d;
	logic             awaiting_q, awaiting_d;
	logic             reply_pending_q, reply_pending_d;
	logic [7:0]       reply_cmd_q, reply_cmd_d;
	logic [8:0]       wait_q, wait_d;

	// Event queue.
	logic        ram_we;
	logic [15:0] ram_wdata;
	logic [15:0] ram_rdata;
	logic        bypass_q;
	logic [15:0] bypass_data_q;
	logic [15:0] head_entry;

	// Transmit register.
	logic       ser_active_q;
	logic [2:0] ser_slot_q;
	logic       ser_len2_q;
	logic [7:0] ser_cmd_q;
	logic [7:0] ser_d0_q;
	logic [7:0] ser_d1_q;
	logic [7:0] ser_xor_q;
	logic [1:0] ser_kind_q;
	logic       ser_drop_q;
	logic       ser_load;
	logic       ser_load_head;
	logic [1:0] ser_load_kind;
	logic       ser_load_drop;
	logic       beat_fire;

	// Retry timing.
	logic [5:0] iv;
	logic [2:0] lim;
	logic [8:0] last_tick;
	logic [8:0] wait_inc;
	logic       on_multiple;
	logic       retx;

	flsw_pkg::rx_frame_t rx_frame;

	//------------------------------------------------------------------
	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_interval_q <= flsw_pkg::RETRY_INTERVAL_RST;
			retry_limit_q    <= flsw_pkg::RETRY_LIMIT_RST;
			max_data_len_q   <= flsw_pkg::MAX_DATA_LEN_RST;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				flsw_pkg::REG_RETRY_INTERVAL: retry_interval_q <= pwdata[5:0];
				flsw_pkg::REG_RETRY_LIMIT:    retry_limit_q    <= pwdata[2:0];
				flsw_pkg::REG_MAX_DATA_LEN:   max_data_len_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			flsw_pkg::REG_RETRY_INTERVAL: prdata = {26'd0, retry_interval_q};
			flsw_pkg::REG_RETRY_LIMIT:    prdata = {29'd0, retry_limit_q};
			flsw_pkg::REG_MAX_DATA_LEN:   prdata = {27'd0, max_data_len_q};
			default:                      prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Input register.
	// Only a tick that could start a frame has to wait for the transmit register.
	assign s1_go   = !(operation_s1 == flsw_pkg::OP_TICK && ser_active_q && !link_busy_q);
	assign s1_fire = valid_s1 && s1_go;
	assign item.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			operation_s1  <= item.operation;
			rx_data_s1    <= item.rx_data;
			key_code_s1   <= item.key_code;
			key_action_s1 <= item.key_action;
		end
	end

	//------------------------------------------------------------------
	// Receive parser.
	flsw_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s1_fire && operation_s1 == flsw_pkg::OP_RX_BYTE),
		.byte_data  (rx_data_s1),
		.max_len    (max_data_len_q),
		.frame      (rx_frame)
	);

	//------------------------------------------------------------------
	// Retry timing: a register value of zero acts as one. The counter never
	// passes the drop point, so a retransmission point below it is one of the
	// first six multiples of the interval.
	assign iv        = (retry_interval_q == 6'd0) ? 6'd1 : retry_interval_q;
	assign lim       = (retry_limit_q == 3'd0) ? 3'd1 : retry_limit_q;
	assign last_tick = {3'd0, iv} * {6'd0, lim};
	assign wait_inc  = wait_q + 9'd1;

	always_comb begin
		on_multiple = 1'b0;
		for (int k = 1; k <= 6; k++) begin
			if (wait_inc == 9'({3'd0, iv} * 9'(k))) on_multiple = 1'b1;
		end
	end

	assign retx = on_multiple || (wait_inc >= last_tick);

	//------------------------------------------------------------------
	// Item execution.
	always_comb begin
		head_d          = head_q;
		tail_d          = tail_q;
		count_d         = count_q;
		link_busy_d     = link_busy_q;
		awaiting_d      = awaiting_q;
		reply_pending_d = reply_pending_q;
		reply_cmd_d     = reply_cmd_q;
		wait_d          = wait_q;
		ram_we          = 1'b0;
		ser_load        = 1'b0;
		ser_load_head   = 1'b0;
		ser_load_kind   = flsw_pkg::KIND_REPLY;
		ser_load_drop   = 1'b0;
		if (s1_fire) begin
			unique case (operation_s1)
				flsw_pkg::OP_TICK: begin
					if (!link_busy_q) begin
						priority if (reply_pending_q) begin
							reply_pending_d = 1'b0;
							link_busy_d     = 1'b1;
							ser_load        = 1'b1;
						end else if (awaiting_q) begin
							wait_d = wait_inc;
							if (retx) begin
								link_busy_d   = 1'b1;
								ser_load      = 1'b1;
								ser_load_head = 1'b1;
								ser_load_kind = flsw_pkg::KIND_RETRY;
								if (wait_inc >= last_tick) begin
									ser_load_drop = 1'b1;
									wait_d        = '0;
									awaiting_d    = 1'b0;
									head_d        = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
									count_d       = count_q - 1'b1;
								end
							end
						end else if (count_q != '0) begin
							link_busy_d   = 1'b1;
							awaiting_d    = 1'b1;
							ser_load      = 1'b1;
							ser_load_head = 1'b1;
							ser_load_kind = flsw_pkg::KIND_FIRST;
						end
					end
				end
				flsw_pkg::OP_RX_BYTE: begin
					if (rx_frame.good) begin
						if (rx_frame.command < flsw_pkg::CMD_ACK_LIMIT) begin
							reply_pending_d = 1'b1;
							reply_cmd_d     = rx_frame.command;
						end else if (awaiting_q && count_q != '0 &&
						             rx_frame.command == flsw_pkg::CMD_KEY_EVENT) begin
							awaiting_d = 1'b0;
							wait_d     = '0;
							head_d     = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
							count_d    = count_q - 1'b1;
						end
					end
				end
				flsw_pkg::OP_KEY: begin
					if (count_q != FULL_CNT) begin
						ram_we  = 1'b1;
						tail_d  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				flsw_pkg::OP_TX_DONE: link_busy_d = 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q          <= '0;
			tail_q          <= '0;
			count_q         <= '0;
			link_busy_q     <= 1'b0;
			awaiting_q      <= 1'b0;
			reply_pending_q <= 1'b0;
			reply_cmd_q     <= '0;
			wait_q          <= '0;
		end else begin
			head_q          <= head_d;
			tail_q          <= tail_d;
			count_q         <= count_d;
			link_busy_q     <= link_busy_d;
			awaiting_q      <= awaiting_d;
			reply_pending_q <= reply_pending_d;
			reply_cmd_q     <= reply_cmd_d;
			wait_q          <= wait_d;
		end
	end

	//------------------------------------------------------------------
	// Event queue. The RAM is read at the next head, so its registered output
	// holds the current head entry; a write to that same entry is forwarded.
	assign ram_wdata = {key_code_s1, key_action_s1};

	flsw_ram #(
		.WIDTH (16),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.raddr (head_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
		end else begin
			bypass_q <= ram_we && (tail_q == head_d);
		end
	end

	always_ff @(posedge clk) begin
		bypass_data_q <= ram_wdata;
	end

	assign head_entry = bypass_q ? bypass_data_q : ram_rdata;

	//------------------------------------------------------------------
	// Transmit register.
	assign beat_fire = beat.valid && beat.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_active_q <= 1'b0;
			ser_slot_q   <= SLOT_SOF;
		end else if (ser_load) begin
			ser_active_q <= 1'b1;
			ser_slot_q   <= SLOT_SOF;
		end else if (beat_fire) begin
			if (ser_slot_q == SLOT_EOF) begin
				ser_active_q <= 1'b0;
			end else if (ser_slot_q == SLOT_CMD && !ser_len2_q) begin
				ser_slot_q <= SLOT_XOR;
			end else begin
				ser_slot_q <= ser_slot_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			ser_len2_q <= ser_load_head;
			ser_kind_q <= ser_load_kind;
			ser_drop_q <= ser_load_drop;
			ser_d0_q   <= head_entry[15:8];
			ser_d1_q   <= head_entry[7:0];
			if (ser_load_head) begin
				ser_cmd_q <= flsw_pkg::CMD_KEY_EVENT;
				ser_xor_q <= flsw_pkg::KEY_DATA_LEN ^ flsw_pkg::CMD_KEY_EVENT ^
				             head_entry[15:8] ^ head_entry[7:0];
			end else begin
				// A reply has no data, so its check byte is the command itself.
				ser_cmd_q <= reply_cmd_q;
				ser_xor_q <= reply_cmd_q;
			end
		end
	end

	assign beat.valid        = ser_active_q;
	assign beat.frame_end    = (ser_slot_q == SLOT_EOF);
	assign beat.frame_kind   = ser_kind_q;
	assign beat.head_dropped = ser_drop_q;

	always_comb begin
		unique case (ser_slot_q)
			SLOT_SOF: beat.tx_data = flsw_pkg::FRAME_SOF;
			SLOT_LEN: beat.tx_data = ser_len2_q ? flsw_pkg::KEY_DATA_LEN : 8'd0;
			SLOT_CMD: beat.tx_data = ser_cmd_q;
			SLOT_D0:  beat.tx_data = ser_d0_q;
			SLOT_D1:  beat.tx_data = ser_d1_q;
			SLOT_XOR: beat.tx_data = ser_xor_q;
			SLOT_EOF: beat.tx_data = flsw_pkg::FRAME_EOF;
			default:  beat.tx_data = flsw_pkg::FRAME_EOF;
		endcase
	end
endmodule

### rtl/flsw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module flsw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/flsw_parser.sv
// Receive-side frame parser: takes one byte per strobe and flags a checked frame.
// Depends on flsw_pkg.
module flsw_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic [7:0]         byte_data,
	input  logic [4:0]         max_len,
	output flsw_pkg::rx_frame_t frame
);
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_XOR  = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	logic [2:0] phase_q, phase_d;
	logic [7:0] command_q, command_d;
	logic [7:0] xor_q, xor_d;
	logic [4:0] remaining_q, remaining_d;
	logic [2:0] reject_phase;

	// A rejected byte that is itself a start byte opens a new frame at once.
	assign reject_phase = (byte_data == flsw_pkg::FRAME_SOF) ? PH_LEN : PH_HUNT;

	always_comb begin
		phase_d     = phase_q;
		command_d   = command_q;
		xor_d       = xor_q;
		remaining_d = remaining_q;
		frame       = '0;
		frame.command = command_q;
		if (byte_valid) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (byte_data == flsw_pkg::FRAME_SOF) phase_d = PH_LEN;
				end
				PH_LEN: begin
					if (byte_data > {3'b000, max_len}) begin
						phase_d = reject_phase;
					end else begin
						remaining_d = byte_data[4:0];
						xor_d       = byte_data;
						phase_d     = PH_CMD;
					end
				end
				PH_CMD: begin
					command_d = byte_data;
					xor_d     = xor_q ^ byte_data;
					phase_d   = (remaining_q != 5'd0) ? PH_DATA : PH_XOR;
				end
				PH_DATA: begin
					xor_d       = xor_q ^ byte_data;
					remaining_d = remaining_q - 5'd1;
					if (remaining_q == 5'd1) phase_d = PH_XOR;
				end
				PH_XOR: begin
					phase_d = (byte_data != xor_q) ? reject_phase : PH_END;
				end
				PH_END: begin
					if (byte_data != flsw_pkg::FRAME_EOF) begin
						phase_d = reject_phase;
					end else begin
						phase_d    = PH_HUNT;
						frame.good = 1'b1;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			command_q   <= '0;
			xor_q       <= '0;
			remaining_q <= '0;
		end else begin
			phase_q     <= phase_d;
			command_q   <= command_d;
			xor_q       <= xor_d;
			remaining_q <= remaining_d;
		end
	end
endmodule

### rtl/flsw_checker.sv
// Port-level checker of the framed link engine and its bind to the top level.
// Depends on flsw_pkg and framed_link_stop_and_wait_engine.
module flsw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       beat_valid,
	input logic       beat_ready,
	input logic [7:0] tx_data,
	input logic       frame_end,
	input logic [1:0] frame_kind,
	input logic       head_dropped
);
	// A stalled beat keeps its byte.
	a_beat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && !beat_ready |=> beat_valid && $stable(tx_data))
		else $error("transmit beat changed while stalled");

	// The closing byte of every frame is the end byte.
	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && frame_end |-> tx_data == flsw_pkg::FRAME_EOF)
		else $error("frame end flagged on a byte other than the end byte");

	// Only a retransmission may drop the head.
	a_drop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && head_dropped |-> frame_kind == flsw_pkg::KIND_RETRY)
		else $error("head dropped on a frame that is not a retransmission");

	// A frame goes out without gaps and keeps its kind to the end.
	a_frame_whole: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && beat_ready && !frame_end |=>
			beat_valid && frame_kind == $past(frame_kind) &&
			head_dropped == $past(head_dropped))
		else $error("frame broken off or changed kind part way");
endmodule

bind framed_link_stop_and_wait_engine flsw_checker u_flsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.beat_valid   (beat.valid),
	.beat_ready   (beat.ready),
	.tx_data      (beat.tx_data),
	.frame_end    (beat.frame_end),
	.frame_kind   (beat.frame_kind),
	.head_dropped (beat.head_dropped)
);

### tb/tb_top.sv
// Self-checking bench for the framed link stop-and-wait engine: a directed table, then
// random traffic per register setting, every transmitted beat checked against the table or a predictor.
// Depends on flsw_pkg, flsw_item_if, flsw_beat_if and the engine RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QDEPTH       = 8;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned PHASE_ITEMS  = 80;

	typedef enum logic [2:0] {HUNT, GET_LEN, GET_CMD, GET_DATA, GET_XOR, GET_END} rx_phase_e;
	typedef enum int {FAULT_NONE, FAULT_LENGTH, FAULT_CHECK, FAULT_END} frame_fault_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] kind;
		logic       dropped;
	} tx_byte_t;

	// One directed step; typed rows carry the frame they must produce (if any).
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx;
		logic [7:0] kc;
		logic [7:0] ka;
		logic       typed;
		logic       emits;
		logic [1:0] kind;
		logic       drop;
		logic [7:0] cmd;
		logic [7:0] len;
		logic [7:0] d0;
		logic [7:0] d1;
	} dir_row_t;

	localparam dir_row_t DIRECTED [28] = '{
		// nothing queued straight after reset, finish while idle, noise while hunting
		'{flsw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_TX_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'h55, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		// command frame with the highest command that asks for a reply
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_SOF, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_EOF, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h7F, 8'h00, 8'h00, 8'h00},
		// the link is still busy, so this tick does nothing
		'{flsw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_TX_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_KEY, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, flsw_pkg::KIND_FIRST, 1'b0,
			flsw_pkg::CMD_KEY_EVENT, flsw_pkg::KEY_DATA_LEN, 8'hFF, 8'h00},
		'{flsw_pkg::OP_TX_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		// length one above the limit, then a bad check byte that is itself a start byte
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_SOF, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'd21, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_SOF, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::CMD_KEY_EVENT, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_SOF, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::CMD_KEY_EVENT, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::CMD_KEY_EVENT, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_EOF, 8'h00, 8'h00, 1'b0, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		// the acknowledge has emptied the queue
		'{flsw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_KEY, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{flsw_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, flsw_pkg::KIND_FIRST, 1'b0,
			flsw_pkg::CMD_KEY_EVENT, flsw_pkg::KEY_DATA_LEN, 8'h00, 8'hFF},
		'{flsw_pkg::OP_TX_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0,
			flsw_pkg::KIND_REPLY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [flsw_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	flsw_item_if item_ch ();
	flsw_beat_if beat_ch ();

	framed_link_stop_and_wait_engine #(.QUEUE_DEPTH(QDEPTH)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.beat    (beat_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor copy of the engine state.
	logic [15:0] ev_store [QDEPTH];
	int unsigned ev_head, ev_tail, ev_count;
	logic        tx_busy, ack_wait, reply_due;
	logic [7:0]  reply_cmd;
	logic [8:0]  retry_ticks;
	rx_phase_e   rx_phase;
	logic [4:0]  rx_left;
	logic [7:0]  rx_cmd, rx_sum;
	logic [5:0]  cfg_interval;
	logic [2:0]  cfg_limit;
	logic [4:0]  cfg_maxlen;

	tx_byte_t    new_tx [$];
	tx_byte_t    awaited_tx [$];

	bit          calm = 1'b0;
	logic        hold_req = 1'b0;
	int unsigned items_done = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic frame_out(input logic [7:0] cmd, len, d0, d1, input logic [1:0] kind,
			input logic drop);
		logic [7:0] sum;
		sum = len ^ cmd;
		new_tx.push_back({flsw_pkg::FRAME_SOF, 1'b0, kind, drop});
		new_tx.push_back({len, 1'b0, kind, drop});
		new_tx.push_back({cmd, 1'b0, kind, drop});
		if (len == flsw_pkg::KEY_DATA_LEN) begin
			new_tx.push_back({d0, 1'b0, kind, drop});
			new_tx.push_back({d1, 1'b0, kind, drop});
			sum = sum ^ d0 ^ d1;
		end
		new_tx.push_back({sum, 1'b0, kind, drop});
		new_tx.push_back({flsw_pkg::FRAME_EOF, 1'b1, kind, drop});
	endtask

	task automatic head_out(input logic [1:0] kind, input logic drop);
		frame_out(flsw_pkg::CMD_KEY_EVENT, flsw_pkg::KEY_DATA_LEN, ev_store[ev_head][15:8],
			ev_store[ev_head][7:0], kind, drop);
	endtask

	task automatic drop_head();
		if (ev_count > 0) begin
			ev_head = (ev_head + 1) % QDEPTH;
			ev_count--;
		end
	endtask

	task automatic predict_tick();
		int unsigned iv, lim, last;
		if (tx_busy)
			return;
		if (reply_due) begin
			reply_due = 1'b0;
			tx_busy = 1'b1;
			frame_out(reply_cmd, 8'h00, 8'h00, 8'h00, flsw_pkg::KIND_REPLY, 1'b0);
			return;
		end
		if (ack_wait) begin
			// A register value of zero behaves as one.
			iv = (cfg_interval == 0) ? 1 : cfg_interval;
			lim = (cfg_limit == 0) ? 1 : cfg_limit;
			last = iv * lim;
			retry_ticks = retry_ticks + 9'd1;
			if ((retry_ticks % iv) != 0 && retry_ticks < last)
				return;
			tx_busy = 1'b1;
			if (retry_ticks >= last) begin
				head_out(flsw_pkg::KIND_RETRY, 1'b1);
				retry_ticks = '0;
				ack_wait = 1'b0;
				drop_head();
			end else begin
				head_out(flsw_pkg::KIND_RETRY, 1'b0);
			end
			return;
		end
		if (ev_count > 0) begin
			tx_busy = 1'b1;
			ack_wait = 1'b1;
			head_out(flsw_pkg::KIND_FIRST, 1'b0);
		end
	endtask

	task automatic predict_rx(input logic [7:0] b);
		case (rx_phase)
			HUNT: begin
				if (b == flsw_pkg::FRAME_SOF)
					rx_phase = GET_LEN;
			end
			GET_LEN: begin
				if (b > cfg_maxlen) begin
					rx_phase = (b == flsw_pkg::FRAME_SOF) ? GET_LEN : HUNT;
				end else begin
					rx_left = b[4:0];
					rx_sum = b;
					rx_phase = GET_CMD;
				end
			end
			GET_CMD: begin
				rx_cmd = b;
				rx_sum = rx_sum ^ b;
				rx_phase = (rx_left != 0) ? GET_DATA : GET_XOR;
			end
			GET_DATA: begin
				rx_sum = rx_sum ^ b;
				rx_left = rx_left - 5'd1;
				if (rx_left == 0)
					rx_phase = GET_XOR;
			end
			GET_XOR: begin
				if (b != rx_sum)
					rx_phase = (b == flsw_pkg::FRAME_SOF) ? GET_LEN : HUNT;
				else
					rx_phase = GET_END;
			end
			GET_END: begin
				if (b != flsw_pkg::FRAME_EOF) begin
					rx_phase = (b == flsw_pkg::FRAME_SOF) ? GET_LEN : HUNT;
				end else begin
					rx_phase = HUNT;
					if (rx_cmd < flsw_pkg::CMD_ACK_LIMIT) begin
						reply_due = 1'b1;
						reply_cmd = rx_cmd;
					end else if (ack_wait && ev_count > 0 &&
					             rx_cmd == flsw_pkg::CMD_KEY_EVENT) begin
						ack_wait = 1'b0;
						drop_head();
						retry_ticks = '0;
					end
				end
			end
			default: rx_phase = HUNT;
		endcase
	endtask

	task automatic predict_item(input logic [1:0] op, input logic [7:0] rx, kc, ka);
		new_tx.delete();
		case (op)
			flsw_pkg::OP_TICK:    predict_tick();
			flsw_pkg::OP_RX_BYTE: predict_rx(rx);
			flsw_pkg::OP_KEY: begin
				if (ev_count < QDEPTH) begin
					ev_store[ev_tail] = {kc, ka};
					ev_tail = (ev_tail + 1) % QDEPTH;
					ev_count++;
				end
			end
			default:              tx_busy = 1'b0;
		endcase
	endtask

	task automatic queue_new_tx();
		foreach (new_tx[i])
			awaited_tx.push_back(new_tx[i]);
	endtask

	// Offers one item, holds it until accepted, then runs the predictor on it.
	task automatic send(input logic [1:0] op, input logic [7:0] rx, kc, ka);
		if (!calm && $urandom_range(99, 0) < 16) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.operation  <= op;
		item_ch.rx_data    <= rx;
		item_ch.key_code   <= kc;
		item_ch.key_action <= ka;
		do @(posedge clk); while (!item_ch.ready);
		predict_item(op, rx, kc, ka);
	endtask

	task automatic drive(input logic [1:0] op, input logic [7:0] rx);
		send(op, rx, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
		queue_new_tx();
		items_done++;
	endtask

	task automatic drive_any(input logic [1:0] op);
		drive(op, 8'($urandom_range(255, 0)));
	endtask

	// A received frame with random content; about a quarter are broken in one place.
	task automatic send_rx_frame();
		int unsigned len, cap, pick;
		logic [7:0] cmd, sum, b;
		frame_fault_e fault;
		cap = (cfg_maxlen < 2) ? cfg_maxlen : 2;
		len = ($urandom_range(3, 0) == 0) ? $urandom_range(cfg_maxlen, 0) : $urandom_range(cap, 0);
		pick = $urandom_range(9, 0);
		if (pick < 4)
			cmd = 8'($urandom_range(127, 0));
		else if (pick < 8)
			cmd = flsw_pkg::CMD_KEY_EVENT;
		else
			cmd = 8'($urandom_range(255, 128));
		fault = FAULT_NONE;
		if ($urandom_range(3, 0) == 0)
			fault = frame_fault_e'($urandom_range(FAULT_END, FAULT_LENGTH));
		drive(flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_SOF);
		if (fault == FAULT_LENGTH) begin
			drive(flsw_pkg::OP_RX_BYTE, 8'($urandom_range(255, cfg_maxlen + 1)));
			return;
		end
		drive(flsw_pkg::OP_RX_BYTE, 8'(len));
		sum = 8'(len) ^ cmd;
		drive(flsw_pkg::OP_RX_BYTE, cmd);
		repeat (len) begin
			b = 8'($urandom_range(255, 0));
			sum = sum ^ b;
			drive(flsw_pkg::OP_RX_BYTE, b);
		end
		if (fault == FAULT_CHECK) begin
			drive(flsw_pkg::OP_RX_BYTE, sum ^ 8'($urandom_range(255, 1)));
			return;
		end
		drive(flsw_pkg::OP_RX_BYTE, sum);
		if (fault == FAULT_END) begin
			b = 8'($urandom_range(255, 0));
			if (b == flsw_pkg::FRAME_EOF || $urandom_range(1, 0) == 0)
				b = flsw_pkg::FRAME_SOF;
			drive(flsw_pkg::OP_RX_BYTE, b);
		end else begin
			drive(flsw_pkg::OP_RX_BYTE, flsw_pkg::FRAME_EOF);
		end
	endtask

	task automatic run_random(input int unsigned count, input bit press);
		int unsigned start, pick;
		start = items_done;
		while (items_done < start + count) begin
			if (press && !hold_req && items_done >= start + 10)
				hold_req <= 1'b1;
			pick = $urandom_range(99, 0);
			if (pick < 20) begin
				drive_any(flsw_pkg::OP_KEY);
			end else if (pick < 45) begin
				drive_any(flsw_pkg::OP_TICK);
				if ($urandom_range(3, 0) != 0)
					drive_any(flsw_pkg::OP_TX_DONE);
			end else if (pick < 65) begin
				send_rx_frame();
			end else if (pick < 73) begin
				drive(flsw_pkg::OP_RX_BYTE, ($urandom_range(3, 0) == 0) ? flsw_pkg::FRAME_SOF
					: 8'($urandom_range(255, 0)));
			end else if (pick < 83) begin
				drive_any(flsw_pkg::OP_TX_DONE);
			end else begin
				// A run of ticks long enough to reach retransmissions and drops.
				repeat ($urandom_range(40, 3)) begin
					drive_any(flsw_pkg::OP_TICK);
					if ($urandom_range(9, 0) != 0)
						drive_any(flsw_pkg::OP_TX_DONE);
				end
			end
		end
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (awaited_tx.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes each of the three registers in turn and reads each one back after its write.
	task automatic configure(input logic [5:0] iv, input logic [2:0] lim, input logic [4:0] mdl);
		logic [1:0]  regs [3];
		logic [31:0] vals [3];
		regs = '{flsw_pkg::REG_RETRY_INTERVAL, flsw_pkg::REG_RETRY_LIMIT,
			flsw_pkg::REG_MAX_DATA_LEN};
		vals = '{32'(iv), 32'(lim), 32'(mdl)};
		for (int i = 0; i < 3; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {regs[i], 2'b00};
			pwdata  <= vals[i];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== vals[i]) begin
				$display("%0t: register %0d expected %h got %h", $time, regs[i], vals[i], prdata);
				errors++;
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		cfg_interval = iv;
		cfg_limit = lim;
		cfg_maxlen = mdl;
	endtask

	always @(posedge clk) begin
		tx_byte_t got, want;
		if (beat_ch.valid && beat_ch.ready) begin
			got = {beat_ch.tx_data, beat_ch.frame_end, beat_ch.frame_kind, beat_ch.head_dropped};
			if (awaited_tx.size() == 0) begin
				$display("%0t: unexpected beat expected none got %h", $time, got);
				errors++;
			end else begin
				want = awaited_tx.pop_front();
				if (got.data !== want.data) begin
					$display("%0t: tx_data expected %h got %h", $time, want.data, got.data);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: frame_end expected %b got %b", $time, want.last, got.last);
					errors++;
				end
				if (got.kind !== want.kind) begin
					$display("%0t: frame_kind expected %0d got %0d", $time, want.kind, got.kind);
					errors++;
				end
				if (got.dropped !== want.dropped) begin
					$display("%0t: head_dropped expected %b got %b", $time, want.dropped,
						got.dropped);
					errors++;
				end
			end
		end
	end

	// Receiving side: random back-pressure, plus one long hold-off on request.
	initial begin
		bit held;
		held = 1'b0;
		beat_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				beat_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			beat_ch.ready <= calm || ($urandom_range(99, 0) >= 16);
		end
	end

	initial begin
		dir_row_t row;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = flsw_pkg::OP_TICK;
		item_ch.rx_data = '0;
		item_ch.key_code = '0;
		item_ch.key_action = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		ev_head = 0;
		ev_tail = 0;
		ev_count = 0;
		tx_busy = 1'b0;
		ack_wait = 1'b0;
		reply_due = 1'b0;
		reply_cmd = '0;
		retry_ticks = '0;
		rx_phase = HUNT;
		rx_left = '0;
		rx_cmd = '0;
		rx_sum = '0;
		cfg_interval = flsw_pkg::RETRY_INTERVAL_RST;
		cfg_limit = flsw_pkg::RETRY_LIMIT_RST;
		cfg_maxlen = flsw_pkg::MAX_DATA_LEN_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			send(row.op, row.rx, row.kc, row.ka);
			if (row.typed) begin
				new_tx.delete();
				if (row.emits)
					frame_out(row.cmd, row.len, row.d0, row.d1, row.kind, row.drop);
			end
			queue_new_tx();
		end

		settle();
		configure(6'd1, 3'd1, 5'd0);
		run_random(PHASE_ITEMS, 1'b0);

		settle();
		configure(6'd63, 3'd7, 5'd27);
		run_random(PHASE_ITEMS, 1'b1);

		settle();
		configure(6'd0, 3'd0, 5'd5);
		run_random(PHASE_ITEMS, 1'b0);

		settle();
		calm = 1'b1;
		configure(6'($urandom_range(12, 2)), 3'($urandom_range(4, 1)),
			5'($urandom_range(27, 0)));
		run_random(PHASE_ITEMS, 1'b0);

		settle();
		calm = 1'b0;
		configure(6'($urandom_range(12, 2)), 3'($urandom_range(4, 1)),
			5'($urandom_range(27, 0)));
		run_random(PHASE_ITEMS, 1'b0);

		settle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
rtl/flsw_pkg.sv
rtl/flsw_item_if.sv
rtl/flsw_beat_if.sv
rtl/flsw_ram.sv
rtl/flsw_parser.sv
rtl/framed_link_stop_and_wait_engine.sv
rtl/flsw_checker.sv
tb/tb_top.sv
